>>> hw/rtl/gb3_pkg.sv
package gb3_pkg;

    localparam int TDATA_W      = 24;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 12;
    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 12;

    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = 11'd640;
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = 12'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int KSIZE = 3;
    localparam int TAPS  = KSIZE * KSIZE;

    localparam longint unsigned CORNER_PPM = 77847;
    localparam longint unsigned EDGE_PPM   = 123317;
    localparam longint unsigned CENTER_PPM = 195346;
    localparam longint unsigned PPM_SCALE  = 1000000;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    typedef pixel_t [TAPS-1:0] win_t;

    typedef struct packed {
        pixel_t upper;
        pixel_t lower;
    } lpair_t;

    typedef struct packed {
        logic frame_end;
        logic last_in_step;
    } tag_t;

    typedef struct packed {
        tag_t   tag;
        pixel_t px;
    } res_t;

endpackage

>>> hw/rtl/gaussian_blur_3x3_rgb.sv
// Streaming 3x3 Gaussian blur of RGB pixels in raster order. The block takes one
// item per clock cycle with no gaps of its own: each pixel makes one read-modify-write
// of the line-store memory (MAX_WIDTH entries, each holding the two rows above), with
// the previous write forwarded to the next read, and each drain reads two memory
// columns, one through each read port. Every result passes the stage-1 register and
// the registers of its blur lane into a 16-entry queue; s_tready drops only
// when that queue, counting results still in flight, cannot take two more. Output
// trails input by one row and one column; after the last pixel of a frame, one drain
// item (s_tuser high) per column flushes the final row, and the last one ends the frame.
module gaussian_blur_3x3_rgb #(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gb3_pkg::TDATA_W-1:0]     s_tdata,   // red_in, green_in, blue_in
    input  logic                            s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gb3_pkg::TDATA_W-1:0]     m_tdata,   // red_out, green_out, blue_out
    output logic                            m_tlast,
    output logic                            m_tuser,   // last_in_step
    input  logic                            cfg_wr_en,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import gb3_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WORD_W = $bits(lpair_t);

    typedef struct packed {
        logic [COL_W-1:0] addr_a;
        logic [COL_W-1:0] addr_b;
        pixel_t           pixel;
        logic             ge1;
        logic             ge2;
        logic             col_one;
        logic             emit1;
        logic             emit2;
        logic             wide;
        logic             first;
        logic             last;
    } s1_t;

    logic [IMG_WIDTH_W-1:0]  image_width_reg;
    logic [IMG_HEIGHT_W-1:0] image_height_reg;
    logic [COL_W-1:0]        col_reg;
    logic [COL_W-1:0]        col_next;
    logic [IMG_HEIGHT_W-1:0] row_reg;
    logic [IMG_HEIGHT_W-1:0] row_next;
    logic [FIFO_CW-1:0]      pend_reg;
    logic [FIFO_CW-1:0]      pend_next;

    logic [COL_W-1:0]        width_last;
    logic [IMG_HEIGHT_W-1:0] height_eff;
    logic                    rows_in;
    logic                    col_last;
    logic                    row_ge1;
    logic                    accept;
    logic                    do_pix;
    logic                    do_drain;
    logic [1:0]              nres;
    logic                    out_xfer;
    logic [COL_W-1:0]        rd_addr_b;

    logic                    s1_pix_reg;
    logic                    s1_drain_reg;
    s1_t                     s1_reg;
    s1_t                     s1_next;

    lpair_t                  rd_a;
    lpair_t                  rd_b;
    lpair_t                  a_word;
    lpair_t                  b_word;
    lpair_t                  prev_word;
    lpair_t                  dprev_reg;
    lpair_t                  wr_data;
    logic                    wr_en;
    logic                    fwd_valid_reg;
    logic [COL_W-1:0]        fwd_addr_reg;
    lpair_t                  fwd_data_reg;
    pixel_t                  top_px;
    pixel_t                  mid_px;

    win_t                    win_reg;
    win_t                    win_next;
    win_t                    lane_a_win;
    win_t                    lane_b_win;
    logic                    lane_a_valid;
    logic                    lane_b_valid;
    tag_t                    lane_a_tag;
    tag_t                    lane_b_tag;
    logic                    blur_a_valid;
    logic                    blur_b_valid;
    res_t                    blur_a_res;
    res_t                    blur_b_res;
    res_t                    head;

    always_comb begin
        if (image_width_reg == '0) begin
            width_last = '0;
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            width_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            width_last = COL_W'(image_width_reg - IMG_WIDTH_W'(1));
        end
    end

    assign height_eff = (image_height_reg == '0) ? IMG_HEIGHT_W'(1) : image_height_reg;
    assign rows_in    = (row_reg >= height_eff);
    assign col_last   = (col_reg == width_last);
    assign row_ge1    = (row_reg != '0);
    assign accept     = s_tvalid && s_tready;
    assign do_pix     = accept && !s_tuser && !rows_in;
    assign do_drain   = accept && s_tuser && rows_in;
    assign out_xfer   = m_tvalid && m_tready;
    assign s_tready   = (pend_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign rd_addr_b  = col_last ? '0 : col_reg + COL_W'(1);

    always_comb begin
        nres = 2'd0;
        if (do_pix && row_ge1) begin
            nres = {1'b0, col_reg != '0} + {1'b0, col_last};
        end else if (do_drain) begin
            nres = 2'd1;
        end
        pend_next = pend_reg + FIFO_CW'(nres) - FIFO_CW'(out_xfer);

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr_en) begin
            col_next = '0;
            row_next = '0;
        end else if (do_pix) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_reg + IMG_HEIGHT_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end else if (do_drain) begin
            if (col_last) begin
                col_next = '0;
                row_next = '0;
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end

        s1_next.addr_a  = col_reg;
        s1_next.addr_b  = rd_addr_b;
        s1_next.pixel   = pixel_t'(s_tdata);
        s1_next.ge1     = row_ge1;
        s1_next.ge2     = (row_reg >= IMG_HEIGHT_W'(2));
        s1_next.col_one = (col_reg == COL_W'(1));
        s1_next.emit1   = row_ge1 && (col_reg != '0);
        s1_next.emit2   = row_ge1 && col_last;
        s1_next.wide    = (width_last != '0);
        s1_next.first   = (col_reg == '0);
        s1_next.last    = col_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= IMG_WIDTH_RESET;
            image_height_reg <= IMG_HEIGHT_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            pend_reg         <= '0;
            s1_pix_reg       <= 1'b0;
            s1_drain_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata[IMG_WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata[IMG_HEIGHT_W-1:0];
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            pend_reg      <= pend_next;
            s1_pix_reg    <= do_pix;
            s1_drain_reg  <= do_drain;
            fwd_valid_reg <= wr_en;
        end
    end

    gb3_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (s1_reg.addr_a),
        .wr_data   (wr_data),
        .rd_addr_a (col_reg),
        .rd_data_a (rd_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_b)
    );

    // The write made in the cycle a read was issued is not yet in that read's data.
    always_comb begin
        a_word = (fwd_valid_reg && fwd_addr_reg == s1_reg.addr_a) ? fwd_data_reg : rd_a;
        b_word = '0;
        if (!s1_reg.last) begin
            b_word = (fwd_valid_reg && fwd_addr_reg == s1_reg.addr_b) ? fwd_data_reg : rd_b;
        end
        prev_word = s1_reg.first ? '0 : dprev_reg;

        top_px        = s1_reg.ge2 ? a_word.upper : '0;
        mid_px        = s1_reg.ge1 ? a_word.lower : '0;
        wr_en         = s1_pix_reg;
        wr_data.upper = mid_px;
        wr_data.lower = s1_reg.pixel;

        for (int r = 0; r < KSIZE; r++) begin
            win_next[r*KSIZE]     = win_reg[r*KSIZE+1];
            win_next[r*KSIZE+1]   = win_reg[r*KSIZE+2];
        end
        win_next[2] = top_px;
        win_next[5] = mid_px;
        win_next[8] = s1_reg.pixel;

        if (s1_drain_reg) begin
            lane_a_win    = '0;
            lane_a_win[0] = prev_word.upper;
            lane_a_win[1] = a_word.upper;
            lane_a_win[2] = b_word.upper;
            lane_a_win[3] = prev_word.lower;
            lane_a_win[4] = a_word.lower;
            lane_a_win[5] = b_word.lower;
        end else begin
            lane_a_win = win_next;
            if (s1_reg.col_one) begin
                for (int r = 0; r < KSIZE; r++) begin
                    lane_a_win[r*KSIZE] = '0;
                end
            end
        end
        lane_a_valid            = (s1_pix_reg && s1_reg.emit1) || s1_drain_reg;
        lane_a_tag.frame_end    = s1_drain_reg && s1_reg.last;
        lane_a_tag.last_in_step = s1_drain_reg || !s1_reg.emit2;

        for (int r = 0; r < KSIZE; r++) begin
            lane_b_win[r*KSIZE]   = s1_reg.wide ? win_next[r*KSIZE+1] : '0;
            lane_b_win[r*KSIZE+1] = win_next[r*KSIZE+2];
            lane_b_win[r*KSIZE+2] = '0;
        end
        lane_b_valid            = s1_pix_reg && s1_reg.emit2;
        lane_b_tag.frame_end    = 1'b0;
        lane_b_tag.last_in_step = 1'b1;
    end

    always_ff @(posedge aclk) begin
        s1_reg       <= s1_next;
        fwd_addr_reg <= s1_reg.addr_a;
        fwd_data_reg <= wr_data;
        if (s1_pix_reg) begin
            win_reg <= win_next;
        end
        if (s1_drain_reg) begin
            dprev_reg <= a_word;
        end
    end

    gb3_blur #(
        .COEF_BITS(COEF_BITS)
    ) u_blur_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lane_a_valid),
        .in_win    (lane_a_win),
        .in_tag    (lane_a_tag),
        .out_valid (blur_a_valid),
        .out_res   (blur_a_res)
    );

    gb3_blur #(
        .COEF_BITS(COEF_BITS)
    ) u_blur_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (lane_b_valid),
        .in_win    (lane_b_win),
        .in_tag    (lane_b_tag),
        .out_valid (blur_b_valid),
        .out_res   (blur_b_res)
    );

    gb3_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_a    (blur_a_valid),
        .data_a    (blur_a_res),
        .push_b    (blur_b_valid),
        .data_b    (blur_b_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    assign m_tdata = head.px;
    assign m_tlast = head.tag.frame_end;
    assign m_tuser = head.tag.last_in_step;

endmodule

>>> hw/rtl/gb3_ram.sv
module gb3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_reg[rd_addr_a];
        rd_data_b <= mem_reg[rd_addr_b];
    end

endmodule

>>> hw/rtl/gb3_blur.sv
module gb3_blur #(
    parameter int COEF_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  gb3_pkg::win_t in_win,
    input  gb3_pkg::tag_t in_tag,
    output logic          out_valid,
    output gb3_pkg::res_t out_res
);

    import gb3_pkg::*;

    localparam int SUM_W  = 10;
    localparam int PROD_W = COEF_BITS + SUM_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int QUO_W  = ACC_W - COEF_BITS;

    localparam logic [COEF_BITS-1:0] W_CORNER =
        COEF_BITS'(((CORNER_PPM << COEF_BITS) + PPM_SCALE / 2) / PPM_SCALE);
    localparam logic [COEF_BITS-1:0] W_EDGE =
        COEF_BITS'(((EDGE_PPM << COEF_BITS) + PPM_SCALE / 2) / PPM_SCALE);
    localparam logic [COEF_BITS-1:0] W_CENTER =
        COEF_BITS'(((CENTER_PPM << COEF_BITS) + PPM_SCALE / 2) / PPM_SCALE);
    localparam logic [ACC_W-1:0] HALF = ACC_W'(longint'(1) << (COEF_BITS - 1));

    logic [7:0]        tap [3][TAPS];
    logic [SUM_W-1:0]  csum_reg [3];
    logic [SUM_W-1:0]  esum_reg [3];
    logic [7:0]        mid_reg [3];
    logic [PROD_W-1:0] cprod_reg [3];
    logic [PROD_W-1:0] eprod_reg [3];
    logic [PROD_W-1:0] mprod_reg [3];
    logic [ACC_W-1:0]  acc [3];
    logic [QUO_W-1:0]  quo [3];
    logic [7:0]        sat [3];
    logic              v1_reg;
    logic              v2_reg;
    tag_t              tag1_reg;
    tag_t              tag2_reg;

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            tap[0][k] = in_win[k].red;
            tap[1][k] = in_win[k].green;
            tap[2][k] = in_win[k].blue;
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = ACC_W'(cprod_reg[ch]) + ACC_W'(eprod_reg[ch])
                    + ACC_W'(mprod_reg[ch]) + HALF;
            quo[ch] = acc[ch][ACC_W-1:COEF_BITS];
            sat[ch] = (quo[ch] > QUO_W'(255)) ? 8'hFF : quo[ch][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < 3; ch++) begin
            csum_reg[ch] <= SUM_W'(tap[ch][0]) + SUM_W'(tap[ch][KSIZE-1])
                          + SUM_W'(tap[ch][TAPS-KSIZE]) + SUM_W'(tap[ch][TAPS-1]);
            esum_reg[ch] <= SUM_W'(tap[ch][1]) + SUM_W'(tap[ch][KSIZE])
                          + SUM_W'(tap[ch][2*KSIZE-1]) + SUM_W'(tap[ch][TAPS-2]);
            mid_reg[ch]  <= tap[ch][TAPS/2];
            cprod_reg[ch] <= PROD_W'(csum_reg[ch]) * PROD_W'(W_CORNER);
            eprod_reg[ch] <= PROD_W'(esum_reg[ch]) * PROD_W'(W_EDGE);
            mprod_reg[ch] <= PROD_W'(mid_reg[ch]) * PROD_W'(W_CENTER);
        end
        tag1_reg         <= in_tag;
        tag2_reg         <= tag1_reg;
        out_res.tag      <= tag2_reg;
        out_res.px.red   <= sat[0];
        out_res.px.green <= sat[1];
        out_res.px.blue  <= sat[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_valid <= 1'b0;
        end else begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            out_valid <= v2_reg;
        end
    end

endmodule

>>> hw/rtl/gb3_fifo.sv
module gb3_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_a,
    input  gb3_pkg::res_t data_a,
    input  logic          push_b,
    input  gb3_pkg::res_t data_b,
    output logic          out_valid,
    input  logic          out_ready,
    output gb3_pkg::res_t out_data
);

    import gb3_pkg::*;

    res_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] slot_b;
    logic [FIFO_CW-1:0] count_reg;
    logic [1:0]         pushes;
    logic               pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign pushes    = {1'b0, push_a} + {1'b0, push_b};
    assign slot_b    = push_a ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;

    always_ff @(posedge aclk) begin
        if (push_a) begin
            mem_reg[wr_ptr_reg] <= data_a;
        end
        if (push_b) begin
            mem_reg[slot_b] <= data_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(pushes);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            count_reg  <= count_reg + FIFO_CW'(pushes) - FIFO_CW'(pop);
        end
    end

endmodule

>>> hw/rtl/gb3_checker.sv
module gb3_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [gb3_pkg::TDATA_W-1:0] m_tdata,
    input logic                        m_tlast,
    input logic                        m_tuser
);

    // The frame ends on a drain item, which yields exactly one result.
    a_frame_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("frame end transfer not marked as last of its item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output transfer changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty and ready after reset");

endmodule

bind gaussian_blur_3x3_rgb gb3_checker u_checker (.*);
